// File: hdl/biquad_tdf2_filter_defines.svh
//==============================================================================
// biquad_tdf2_filter_defines
// Assertion macros shared by the biquad filter RTL.
//==============================================================================
`ifndef BIQUAD_TDF2_FILTER_DEFINES_SVH
`define BIQUAD_TDF2_FILTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bq_tdf2_pkg.sv
//==============================================================================
// bq_tdf2_pkg
// Shared types and constants of the transposed direct form II biquad.
//==============================================================================
`default_nettype none

package bq_tdf2_pkg;

    localparam int DEF_CHANNELS     = 2;
    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_COEF_WIDTH   = 32;

    localparam int CHAN_WIDTH       = 1;
    localparam int CFG_INDEX_WIDTH  = 3;

    // Delay words carry this many bits more than a sample.
    localparam int STATE_GUARD      = 24;
    // Bits kept above the sample width after the product shift.
    localparam int PROD_EXTRA       = 18;
    // Fraction bits dropped when a delay-precision sum becomes a sample.
    localparam int ROUND_SHIFT      = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A2 = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_B0,
        S_Y,
        S_A1,
        S_B2,
        S_A2,
        S_D2
    } bq_state_t;

endpackage

`default_nettype wire

// File: hdl/bq_mul.sv
//==============================================================================
// bq_mul
// Shared signed coefficient-by-sample multiplier with the product brought to
// delay-word precision and registered.
//==============================================================================
`default_nettype none

module bq_mul
    import bq_tdf2_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH
)
(
    input  wire logic                                       clk,
    input  wire logic                                       en,
    input  wire logic signed [COEF_WIDTH-1:0]               coef,
    input  wire logic signed [SAMPLE_WIDTH-1:0]             smp,
    output logic signed      [SAMPLE_WIDTH+PROD_EXTRA-1:0]  prod
);

    localparam int FULL_W = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int SHIFT  = COEF_WIDTH - PROD_EXTRA;

    logic signed [FULL_W-1:0]                    full;
    logic signed [SAMPLE_WIDTH+PROD_EXTRA-1:0]   prod_reg;

    assign full = FULL_W'(coef) * FULL_W'(smp);

    // Dropping the low bits is an arithmetic shift that rounds toward minus
    // infinity.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[FULL_W-1:SHIFT];
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: hdl/biquad_tdf2_filter.sv
//==============================================================================
// biquad_tdf2_filter
// Multichannel second-order IIR section in transposed direct form II.
//==============================================================================
// Channel   Handshake              Payload
// in        in_valid / in_stall    sample_in, chan
// out       out_valid / out_stall  sample_out, out_chan
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// From acceptance to a result in the output register, five products pass
// one after another through the single multiplier, then the second delay
// word is finished. The next request is accepted only after the sequencer
// returns to idle, so requests are processed one at a time.
// The input is stalled from acceptance until the delay words are written.
// If the previous result is still held, the last step waits for its release.
// Reset loads b0 with unity gain, clears the other coefficients and all
// delay words.
//==============================================================================
`default_nettype none

`include "biquad_tdf2_filter_defines.svh"

module biquad_tdf2_filter
    import bq_tdf2_pkg::*;
#(
    parameter int CHANNELS     = DEF_CHANNELS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in,
    input  wire logic        [CHAN_WIDTH-1:0]      chan,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed      [SAMPLE_WIDTH-1:0]    sample_out,
    output logic             [CHAN_WIDTH-1:0]      out_chan,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic        [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic signed [COEF_WIDTH-1:0]      cfg_data
);

    localparam int W       = SAMPLE_WIDTH;
    localparam int STATE_W = SAMPLE_WIDTH + STATE_GUARD;
    localparam int PROD_W  = SAMPLE_WIDTH + PROD_EXTRA;
    localparam int ACC_W   = STATE_W + 2;

    localparam logic signed [ACC_W-1:0] Y_MAX  =
        {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN  = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] ST_MAX =
        {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        ACC_W'(1) <<< (ROUND_SHIFT - 1);

    bq_state_t state_reg, state_next;

    logic signed [COEF_WIDTH-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [STATE_W-1:0]    delay_one_reg [CHANNELS];
    logic signed [STATE_W-1:0]    delay_two_reg [CHANNELS];

    logic signed [W-1:0]          x_reg;
    logic signed [W-1:0]          y_reg;
    logic        [CHAN_WIDTH-1:0] chan_reg;
    logic signed [ACC_W-1:0]      acc_reg;

    logic                         out_valid_reg;
    logic signed [W-1:0]          sample_out_reg;
    logic        [CHAN_WIDTH-1:0] out_chan_reg;

    logic                         mul_en;
    logic                         mul_use_y;
    logic signed [COEF_WIDTH-1:0] mul_coef;
    logic signed [PROD_W-1:0]     prod;
    logic signed [ACC_W-1:0]      prod_ext;

    logic                         in_take;
    logic                         out_free;
    logic signed [STATE_W-1:0]    s1_rd, s2_rd;
    logic signed [ACC_W-1:0]      y_sum, y_shift;
    logic signed [W-1:0]          y_sat;
    logic signed [STATE_W-1:0]    st1_sat, st2_sat;
    logic signed [ACC_W-1:0]      st2_sum;

    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign prod_ext  = ACC_W'(prod);

    //--------------------------------------------------------------------------
    // Shared multiplier
    //--------------------------------------------------------------------------
    bq_mul #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .coef (mul_coef),
        .smp  (mul_use_y ? y_reg : x_reg),
        .prod (prod)
    );

    //--------------------------------------------------------------------------
    // Sequencer
    //--------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_take) state_next = S_B0;
            S_B0:   state_next = S_Y;
            S_Y:    state_next = S_A1;
            S_A1:   state_next = S_B2;
            S_B2:   state_next = S_A2;
            S_A2:   state_next = S_D2;
            S_D2:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mul_en    = 1'b0;
        mul_use_y = 1'b0;
        mul_coef  = b0_reg;
        in_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE: in_stall = 1'b0;
            S_B0:
            begin
                mul_en   = 1'b1;
                mul_coef = b0_reg;
            end
            S_Y:
            begin
                mul_en   = 1'b1;
                mul_coef = b1_reg;
            end
            S_A1:
            begin
                mul_en    = 1'b1;
                mul_use_y = 1'b1;
                mul_coef  = a1_reg;
            end
            S_B2:
            begin
                mul_en   = 1'b1;
                mul_coef = b2_reg;
            end
            S_A2:
            begin
                mul_en    = 1'b1;
                mul_use_y = 1'b1;
                mul_coef  = a2_reg;
            end
            S_D2:   in_stall = 1'b1;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    //--------------------------------------------------------------------------
    // Delay word read; a channel beyond the configured count reads as zero.
    //--------------------------------------------------------------------------
    always_comb
    begin
        s1_rd = '0;
        s2_rd = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (32'(chan_reg) == i)
            begin
                s1_rd = delay_one_reg[i];
                s2_rd = delay_two_reg[i];
            end
        end
    end

    //--------------------------------------------------------------------------
    // Rounding and saturation
    //--------------------------------------------------------------------------
    always_comb
    begin
        y_sum   = acc_reg + prod_ext + ROUND_BIAS;
        y_shift = y_sum >>> ROUND_SHIFT;
        if (y_shift > Y_MAX)
            y_sat = Y_MAX[W-1:0];
        else if (y_shift < Y_MIN)
            y_sat = Y_MIN[W-1:0];
        else
            y_sat = y_shift[W-1:0];

        if (acc_reg > ST_MAX)
            st1_sat = ST_MAX[STATE_W-1:0];
        else if (acc_reg < ST_MIN)
            st1_sat = ST_MIN[STATE_W-1:0];
        else
            st1_sat = acc_reg[STATE_W-1:0];

        st2_sum = acc_reg - prod_ext;
        if (st2_sum > ST_MAX)
            st2_sat = ST_MAX[STATE_W-1:0];
        else if (st2_sum < ST_MIN)
            st2_sat = ST_MIN[STATE_W-1:0];
        else
            st2_sat = st2_sum[STATE_W-1:0];
    end

    //--------------------------------------------------------------------------
    // Datapath registers
    //--------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    x_reg    <= sample_in;
                    chan_reg <= chan;
                end
            end
            S_B0:   acc_reg <= ACC_W'(s1_rd);
            S_Y:
            begin
                y_reg   <= y_sat;
                acc_reg <= ACC_W'(s2_rd);
            end
            S_A1:   acc_reg <= acc_reg + prod_ext;
            S_B2:   acc_reg <= acc_reg - prod_ext;
            S_A2:   acc_reg <= prod_ext;
            default: acc_reg <= acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                delay_one_reg[i] <= '0;
                delay_two_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (32'(chan_reg) == i)
                begin
                    if (state_reg == S_A2)
                        delay_one_reg[i] <= st1_sat;
                    if (state_reg == S_D2 && out_free)
                        delay_two_reg[i] <= st2_sat;
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // Coefficient registers
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= {2'b01, {(COEF_WIDTH-2){1'b0}}};
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_B0: b0_reg <= cfg_data;
                REG_B1: b1_reg <= cfg_data;
                REG_B2: b2_reg <= cfg_data;
                REG_A1: a1_reg <= cfg_data;
                REG_A2: a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Output register
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_D2 && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_D2 && out_free)
        begin
            sample_out_reg <= y_reg;
            out_chan_reg   <= chan_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign out_chan   = out_chan_reg;

    //--------------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------------
    `BQ_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_reg == S_B0, "accepted request did not start the sequence")
    `BQ_ASSERT_NOW(a_result_origin, $rose(out_valid), $past(state_reg == S_D2), "result appeared outside the final step")
    `BQ_ASSERT_NEXT(a_final_release, state_reg == S_D2 && out_free, state_reg == S_IDLE && out_valid, "final step did not deliver and release")

endmodule

`default_nettype wire

// File: sim/biquad_tdf2_filter_test.sv
//==============================================================================
// biquad_tdf2_filter_test
// Self-checking bench for the two-channel transposed direct form II biquad.
// A clocked driver feeds sample requests from a queue. A clocked monitor
// compares every filtered sample with a bit-true model kept in the bench.
// Both sides insert random gaps. Coefficients are reloaded between phases,
// while the filter is idle, with edge values, full-range values, small
// values and stable-filter values.
//==============================================================================
`default_nettype none

module biquad_tdf2_filter_test
    import bq_tdf2_pkg::*;
;

    localparam int SW          = DEF_SAMPLE_WIDTH;
    localparam int CW          = DEF_COEF_WIDTH;
    localparam int NCHAN       = DEF_CHANNELS;
    localparam int STW         = SW + STATE_GUARD;
    localparam int PSHIFT      = CW - PROD_EXTRA;
    localparam int NUM_COEFS   = 5;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 16;
    localparam int unsigned LIMIT_CYCLES = 400000;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = REG_A2 + 1'b1;

    localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COEF_ONE = 1 <<< (CW - 2);

    typedef enum int { COEF_FULL, COEF_SMALL, COEF_STABLE, COEF_EDGE } coef_mode_t;

    typedef struct packed {
        logic [SW-1:0]         smp;
        logic [CHAN_WIDTH-1:0] ch;
    } sample_req_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SW-1:0]          sample_in = '0;
    logic [CHAN_WIDTH-1:0]         chan = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SW-1:0]          sample_out;
    logic [CHAN_WIDTH-1:0]         out_chan;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
    logic signed [CW-1:0]          cfg_data = '0;

    // Bench copy of the filter: coefficients and per-channel delay words.
    logic signed [CW-1:0] coef_set [NUM_COEFS];
    longint               dly_one [NCHAN];
    longint               dly_two [NCHAN];

    sample_req_t pending_reqs[$];
    sample_req_t filtered_q[$];

    int          mismatches = 0;
    int unsigned cycle_count = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int          rx_hold_seq = 0;
    int          rx_hold_seen = 0;
    int          rx_hold_left = 0;
    int          tx_gap = 0;
    int          rx_stall_left = 0;
    int          rx_run_left = 0;

    biquad_tdf2_filter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .chan       (chan),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .out_chan   (out_chan),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Coefficient times sample, brought down to delay-word precision.
    function automatic longint scaled_mult(input logic signed [CW-1:0] k, input longint s);
        longint p;
        p = longint'(k) * s;
        return p >>> PSHIFT;
    endfunction

    function automatic sample_req_t filter_sample(input sample_req_t req);
        longint      x;
        longint      y;
        longint      s1;
        longint      s2;
        bit          in_range;
        sample_req_t res;
        x = longint'($signed(req.smp));
        in_range = int'(req.ch) < NCHAN;
        s1 = in_range ? dly_one[req.ch] : 0;
        s2 = in_range ? dly_two[req.ch] : 0;
        y = scaled_mult(coef_set[REG_B0], x) + s1;
        y = clamp((y + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT, SW);
        if (in_range)
        begin
            dly_one[req.ch] = clamp(scaled_mult(coef_set[REG_B1], x)
                                    - scaled_mult(coef_set[REG_A1], y) + s2, STW);
            dly_two[req.ch] = clamp(scaled_mult(coef_set[REG_B2], x)
                                    - scaled_mult(coef_set[REG_A2], y), STW);
        end
        res.smp = y[SW-1:0];
        res.ch  = req.ch;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return SMP_MAX;
        if (r < 6)
            return SMP_MIN;
        if (r < 8)
            return '0;
        if (r < 10)
            return {SW{1'b1}};
        if (r < 40)
            return SW'(int'($urandom_range(0, 2048)) - 1024);
        return SW'($urandom);
    endfunction

    function automatic logic [CW-1:0] pick_coef(input coef_mode_t mode, input bit feedback);
        case (mode)
            COEF_FULL:
                return $urandom;
            COEF_SMALL:
                return int'($urandom_range(0, 1 << 30)) - (1 << 29);
            COEF_STABLE:
                if (feedback)
                    return int'($urandom_range(0, 1 << 29)) - (1 << 28);
                else
                    return int'($urandom_range(0, 1 << 28)) - (1 << 27);
            default:
                case ($urandom_range(0, 4))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return COEF_ONE;
                    3: return -COEF_ONE;
                    default: return '0;
                endcase
        endcase
    endfunction

    // Sender: one request at a time, held steady while the filter stalls it.
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            filtered_q.push_back(filter_sample('{smp: sample_in, ch: chan}));
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && in_stall)
            ;
        else if (tx_gap > 0)
        begin
            tx_gap = tx_gap - 1;
            in_valid <= 1'b0;
        end
        else if (pending_reqs.size() > 0)
        begin
            sample_req_t req;
            req = pending_reqs.pop_front();
            sample_in <= req.smp;
            chan      <= req.ch;
            in_valid  <= 1'b1;
            tx_gap = tx_calm ? 0 : pick_gap();
        end
        else
            in_valid <= 1'b0;
    end

    // Long receiver hold-off, started by bumping rx_hold_seq.
    always @(posedge clk)
    begin
        if (rx_hold_seq != rx_hold_seen)
        begin
            rx_hold_seen <= rx_hold_seq;
            rx_hold_left <= HOLD_CYCLES;
        end
        else if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Receiver: check each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (filtered_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sample %0d chan %0d",
                             sample_out, out_chan);
            end
            else
            begin
                sample_req_t want;
                want = filtered_q.pop_front();
                if (sample_out !== $signed(want.smp) || out_chan !== want.ch)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected sample %0d chan %0d, got sample %0d chan %0d",
                                 $signed(want.smp), want.ch, sample_out, out_chan);
                end
            end
        end
        if (rx_hold_left > 0)
            out_stall <= 1'b1;
        else if (rx_calm)
            out_stall <= 1'b0;
        else if (rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (rx_run_left > 0)
        begin
            rx_run_left = rx_run_left - 1;
            out_stall <= 1'b0;
        end
        else
        begin
            rx_stall_left = pick_gap();
            rx_run_left = $urandom_range(0, 15);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("biquad_tdf2_filter verification failed");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || filtered_q.size() != 0 || in_stall);
    endtask

    task automatic queue_sample(input logic [SW-1:0] smp, input logic [CHAN_WIDTH-1:0] ch);
        pending_reqs.push_back('{smp: smp, ch: ch});
    endtask

    task automatic write_coef(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [CW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // Indexes past the last coefficient are dropped by the filter.
        if (idx <= REG_A2)
            coef_set[idx] = val;
    endtask

    task automatic write_spare();
        write_coef(CFG_INDEX_WIDTH'($urandom_range(REG_SPARE_LO, (1 << CFG_INDEX_WIDTH) - 1)),
                   $urandom);
    endtask

    task automatic load_coefs(input logic [CW-1:0] b0, input logic [CW-1:0] b1,
                              input logic [CW-1:0] b2, input logic [CW-1:0] a1,
                              input logic [CW-1:0] a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
        write_spare();
        @(negedge clk);
    endtask

    task automatic queue_extremes();
        queue_sample(SMP_MAX, 1'b0);
        queue_sample(SMP_MIN, 1'b1);
        queue_sample(SMP_MAX, 1'b1);
        queue_sample(SMP_MIN, 1'b0);
        queue_sample('0, 1'b0);
        queue_sample({SW{1'b1}}, 1'b1);
    endtask

    initial
    begin
        coef_mode_t mode;
        coef_set[REG_B0] = COEF_ONE;
        coef_set[REG_B1] = '0;
        coef_set[REG_B2] = '0;
        coef_set[REG_A1] = '0;
        coef_set[REG_A2] = '0;
        for (int c = 0; c < NCHAN; c++)
        begin
            dly_one[c] = 0;
            dly_two[c] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Unity gain after reset: every sample should come back unchanged.
        queue_sample(SMP_MAX, 1'b0);
        queue_sample(SMP_MIN, 1'b1);
        queue_sample('0, 1'b0);
        queue_sample(SW'(1), 1'b1);
        queue_sample({SW{1'b1}}, 1'b0);
        queue_sample(SMP_MAX, 1'b1);
        wait_idle();

        // Largest gains: the output saturates on both sides.
        load_coefs(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
        queue_extremes();
        wait_idle();

        load_coefs(COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
        queue_extremes();
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph % 4)
                0: mode = COEF_STABLE;
                1: mode = COEF_FULL;
                2: mode = COEF_SMALL;
                default: mode = COEF_EDGE;
            endcase
            tx_calm = (ph == 2);
            rx_calm = (ph == 5);
            load_coefs(pick_coef(mode, 1'b0), pick_coef(mode, 1'b0), pick_coef(mode, 1'b0),
                       pick_coef(mode, 1'b1), pick_coef(mode, 1'b1));
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_sample(pick_sample(), CHAN_WIDTH'($urandom_range(0, NCHAN - 1)));
            // The receiver holds off while plenty of requests remain queued,
            // so the filter fills up and stalls its input.
            if (ph == 3 || ph == 6)
            begin
                do
                    @(negedge clk);
                while (pending_reqs.size() > PHASE_ITEMS - 10);
                rx_hold_seq++;
            end
            wait_idle();
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("biquad_tdf2_filter verification clean");
        else
            $display("biquad_tdf2_filter verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/bq_tdf2_pkg.sv
hdl/bq_mul.sv
hdl/biquad_tdf2_filter.sv
sim/biquad_tdf2_filter_test.sv
